### sv/cda_pkg.sv
// Shared types and constants for the calendar date adder.
// Operation codes, month length table, reciprocal constants, FSM state and
// the command/status structs between controller and datapath, plus leap and month length helpers. No dependencies.
`default_nettype none

package cda_pkg;

	localparam logic [1:0] OP_DAYS   = 2'd0;
	localparam logic [1:0] OP_MONTHS = 2'd1;
	localparam logic [1:0] OP_YEARS  = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	localparam int YEAR_MAX = 16383;

	// floor(v * K >> S) == floor(v / N) over the value ranges used here
	localparam logic [16:0] K12 = 17'd87382;   // /12, S = 20, v < 2^16
	localparam logic [14:0] K25 = 15'd20972;   // /25, S = 19, v < 2^14

	// month 0 and 13..15 never reach the walk; table is padded for safety
	localparam logic [4:0] MONTH_LEN [16] = '{
		5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MDIV,
		ST_MFIX,
		ST_YMUL,
		ST_YMOD,
		ST_WALK,
		ST_CLAMP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic idle;
		logic mdiv;
		logic mfix;
		logic ymul;
		logic ymod;
		logic walk;
		logic clamp;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic       in_valid;
		logic       bad_in;
		logic [1:0] op;
		logic       walk_done;
		logic       out_free;
	} sts_t;

	// Gregorian rule from the low year bits and the year modulo 25
	function automatic logic is_leap(input logic [3:0] y_lo, input logic [4:0] mod25);
		return (y_lo[1:0] == 2'd0) && ((mod25 != 5'd0) || (y_lo == 4'd0));
	endfunction

	function automatic logic [4:0] days_of(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		len = MONTH_LEN[month];
		if (month == 4'd2 && leap) begin
			len = 5'd29;
		end
		return len;
	endfunction

endpackage

`default_nettype wire

### sv/cda_in_if.sv
// Input channel of the calendar date adder: valid/ready plus the date request.
// No dependencies.
`default_nettype none

interface cda_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [15:0] amount;
	logic [13:0]        in_year;
	logic [3:0]         in_month;
	logic signed [6:0]  in_day;

	modport source (output valid, operation, amount, in_year, in_month, in_day,
		input ready);
	modport sink (input valid, operation, amount, in_year, in_month, in_day,
		output ready);
endinterface

`default_nettype wire

### sv/cda_out_if.sv
// Output channel of the calendar date adder: valid/ready plus the result date.
// No dependencies.
`default_nettype none

interface cda_out_if;
	logic              valid;
	logic              ready;
	logic [13:0]       out_year;
	logic [3:0]        out_month;
	logic signed [6:0] out_day;
	logic              range_error;

	modport source (output valid, out_year, out_month, out_day, range_error,
		input ready);
	modport sink (input valid, out_year, out_month, out_day, range_error,
		output ready);
endinterface

`default_nettype wire

### sv/cda_ctrl.sv
// Controller FSM of the calendar date adder: sequences load, month division,
// year mod 25, month walk (add days) or clamp (add months), and output. Depends on cda_pkg.
`default_nettype none

module cda_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cda_pkg::sts_t sts,
	output cda_pkg::cmd_t     cmd
);

	cda_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			cda_pkg::ST_IDLE: begin
				cmd.idle = 1'b1;
				if (sts.in_valid) begin
					state_d = cda_pkg::ST_MDIV;
				end
			end
			cda_pkg::ST_MDIV: begin
				if (sts.bad_in) begin
					state_d = cda_pkg::ST_FIN;
				end else begin
					cmd.mdiv = 1'b1;
					state_d  = cda_pkg::ST_MFIX;
				end
			end
			cda_pkg::ST_MFIX: begin
				cmd.mfix = 1'b1;
				state_d  = cda_pkg::ST_YMUL;
			end
			cda_pkg::ST_YMUL: begin
				cmd.ymul = 1'b1;
				state_d  = cda_pkg::ST_YMOD;
			end
			cda_pkg::ST_YMOD: begin
				cmd.ymod = 1'b1;
				unique case (sts.op)
					cda_pkg::OP_DAYS:   state_d = cda_pkg::ST_WALK;
					cda_pkg::OP_MONTHS: state_d = cda_pkg::ST_CLAMP;
					default:            state_d = cda_pkg::ST_FIN;
				endcase
			end
			cda_pkg::ST_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_done) begin
					state_d = cda_pkg::ST_FIN;
				end
			end
			cda_pkg::ST_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d   = cda_pkg::ST_FIN;
			end
			cda_pkg::ST_FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = cda_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cda_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### sv/cda_dpath.sv
// Datapath of the calendar date adder: input capture, reciprocal divide by 12
// and 25, one-month-per-cycle day walk, day clamp and output register.
// Depends on cda_pkg, cda_in_if, cda_out_if.
`default_nettype none

module cda_dpath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	cda_in_if.sink             request,
	cda_out_if.source          result,
	input  wire cda_pkg::cmd_t cmd,
	output cda_pkg::sts_t      sts
);

	// captured request
	logic [1:0]         op_q;
	logic signed [15:0] amt_q;
	logic [13:0]        y0_q;
	logic [3:0]         m0_q;
	logic signed [6:0]  d0_q;

	// working date
	logic signed [16:0] y_q;
	logic [3:0]         m_q;
	logic signed [16:0] d_q;
	logic [4:0]         ymod25_q;

	// month division
	logic [15:0] v_q;
	logic [11:0] q12_q;
	logic        hi_q, lo_q;
	logic [3:0]  s4_q;
	logic [9:0]  q25_q;

	// output register
	logic              out_valid_q;
	logic [13:0]       out_year_q;
	logic [3:0]        out_month_q;
	logic signed [6:0] out_day_q;
	logic              out_err_q;

	logic               load;
	logic signed [16:0] msum, vx;
	logic               m_hi, m_lo;
	logic [32:0]        prod12;
	logic [15:0]        r12w;
	logic [3:0]         r12;
	logic [28:0]        prod25;
	logic [13:0]        m25w;
	logic               leap_cur;
	logic [4:0]         dim, prev_len;
	logic [3:0]         prev_m;
	logic signed [16:0] dim_s, prev_s;
	logic               over, under;
	logic               bad_in, y_err, fin_err;

	assign load          = cmd.idle && request.valid;
	assign request.ready = cmd.idle;

	assign msum   = $signed({13'd0, m0_q}) + 17'(amt_q);
	assign m_hi   = msum > 17'sd12;
	assign m_lo   = msum < 17'sd1;
	assign vx     = m_hi ? (msum - 17'sd1) : (17'sd12 - msum);
	assign prod12 = 33'(vx[15:0]) * 33'(cda_pkg::K12);

	assign r12w = v_q - {1'b0, q12_q, 3'b000} - {2'b00, q12_q, 2'b00};
	assign r12  = r12w[3:0];

	assign prod25 = 29'(y_q[13:0]) * 29'(cda_pkg::K25);
	assign m25w   = y_q[13:0] - {q25_q, 4'b0000} - {1'b0, q25_q, 3'b000} - {4'b0000, q25_q};

	assign leap_cur = cda_pkg::is_leap(y_q[3:0], ymod25_q);
	assign dim      = cda_pkg::days_of(m_q, leap_cur);
	// previous month of January is December, whose length has no leap term
	assign prev_m   = (m_q == 4'd1) ? 4'd12 : (m_q - 4'd1);
	assign prev_len = cda_pkg::days_of(prev_m, leap_cur);
	assign dim_s    = $signed({12'd0, dim});
	assign prev_s   = $signed({12'd0, prev_len});
	assign over     = d_q > dim_s;
	assign under    = d_q <= 17'sd0;

	assign bad_in  = (m0_q == 4'd0) || (m0_q > 4'd12) || (op_q == cda_pkg::OP_NONE);
	assign y_err   = (y_q < 17'sd0) || (y_q > 17'(cda_pkg::YEAR_MAX));
	assign fin_err = bad_in || y_err;

	always_comb begin
		sts           = '0;
		sts.in_valid  = request.valid;
		sts.bad_in    = bad_in;
		sts.op        = op_q;
		sts.walk_done = !over && !under;
		sts.out_free  = !out_valid_q || result.ready;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_q  <= request.operation;
			amt_q <= request.amount;
			y0_q  <= request.in_year;
			m0_q  <= request.in_month;
			d0_q  <= request.in_day;
			m_q   <= request.in_month;
			if (request.operation == cda_pkg::OP_YEARS) begin
				y_q <= $signed({3'd0, request.in_year}) + 17'(request.amount);
			end else begin
				y_q <= $signed({3'd0, request.in_year});
			end
			if (request.operation == cda_pkg::OP_DAYS) begin
				d_q <= 17'(request.in_day) + 17'(request.amount);
			end else begin
				d_q <= 17'(request.in_day);
			end
		end
		if (cmd.mdiv) begin
			v_q   <= vx[15:0];
			q12_q <= prod12[31:20];
			hi_q  <= m_hi;
			lo_q  <= m_lo;
			s4_q  <= msum[3:0];
		end
		if (cmd.mfix && op_q == cda_pkg::OP_MONTHS) begin
			priority if (hi_q) begin
				y_q <= y_q + $signed({5'd0, q12_q});
				m_q <= r12 + 4'd1;
			end else if (lo_q) begin
				y_q <= y_q - $signed({5'd0, q12_q});
				m_q <= 4'd12 - r12;
			end else begin
				m_q <= s4_q;
			end
		end
		if (cmd.ymul) begin
			q25_q <= prod25[28:19];
		end
		if (cmd.ymod) begin
			ymod25_q <= m25w[4:0];
		end
		if (cmd.walk) begin
			if (over) begin
				d_q <= d_q - dim_s;
				if (m_q == 4'd12) begin
					m_q      <= 4'd1;
					y_q      <= y_q + 17'sd1;
					ymod25_q <= (ymod25_q == 5'd24) ? 5'd0 : (ymod25_q + 5'd1);
				end else begin
					m_q <= m_q + 4'd1;
				end
			end else if (under) begin
				d_q <= d_q + prev_s;
				m_q <= prev_m;
				if (m_q == 4'd1) begin
					y_q      <= y_q - 17'sd1;
					ymod25_q <= (ymod25_q == 5'd0) ? 5'd24 : (ymod25_q - 5'd1);
				end
			end
		end
		if (cmd.clamp && over) begin
			d_q <= dim_s;
		end
		if (cmd.fin) begin
			out_err_q <= fin_err;
			if (fin_err) begin
				out_year_q  <= y0_q;
				out_month_q <= m0_q;
				out_day_q   <= d0_q;
			end else begin
				out_year_q  <= y_q[13:0];
				out_month_q <= m_q;
				out_day_q   <= d_q[6:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_year    = out_year_q;
	assign result.out_month   = out_month_q;
	assign result.out_day     = out_day_q;
	assign result.range_error = out_err_q;

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd)) else $error("more than one datapath command");

	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> out_valid_q) else $error("result not presented after finish");

	a_mod25: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> ymod25_q < 5'd25) else $error("year mod 25 out of range");

	a_month_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_err_q) |-> (out_month_q >= 4'd1 && out_month_q <= 4'd12))
		else $error("good result with bad month");

endmodule

`default_nettype wire

### sv/calendar_date_adder.sv
// Gregorian date adder: adds days, months or years to a date, one item at a time.
// A bad request goes straight to the output register; the others pass month division and
// year mod 25, then add months clamps the day and add days walks month by month.
// Throughput: one request in flight; the next is taken the cycle after the result is
// registered, which waits until the output register is free.
// Reset (arst_n low) clears the controller state and the output valid; no memories.
`default_nettype none

module calendar_date_adder (
	input wire logic  clk,
	input wire logic  arst_n,
	cda_in_if.sink    request,
	cda_out_if.source result
);

	cda_pkg::cmd_t cmd;
	cda_pkg::sts_t sts;

	cda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	cda_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.result  (result),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule

`default_nettype wire

### test/calendar_date_adder_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for calendar_date_adder: directed date edges, then random traffic.
// Predicts each result date and compares it field by field with the output beat.
// Depends on cda_pkg, cda_in_if, cda_out_if and the calendar_date_adder RTL.

module calendar_date_adder_test;

	localparam int QUIET_LIMIT = 5000;   // watchdog limit, well above the longest day walk

	typedef struct {
		logic [1:0]         op;
		logic signed [15:0] amount;
		logic [13:0]        year;
		logic [3:0]         month;
		logic signed [6:0]  day;
	} date_req_t;

	typedef struct {
		logic [13:0]       year;
		logic [3:0]        month;
		logic signed [6:0] day;
		logic              err;
	} date_sum_t;

	logic clk;
	logic arst_n;

	cda_in_if  request_ch();
	cda_out_if result_ch();

	calendar_date_adder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request_ch.sink),
		.result (result_ch.source)
	);

	date_sum_t pending_dates[$];
	bit        send_burst;
	bit        take_burst;
	int        mismatches;
	int        results_checked;
	int        sent_days, sent_months, sent_years, sent_rejected;
	int        quiet_cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------------------------------------------------------- prediction

	function automatic bit leap_year_check(input int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int month_length(input int y, input int m);
		int lengths[1:12];
		lengths = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (m == 2 && leap_year_check(y)) begin
			return 29;
		end
		return lengths[m];
	endfunction

	function automatic date_sum_t add_to_date(input date_req_t r);
		date_sum_t res;
		int amt, y0, m0, d0, y, m, d, s, n, lim;
		bit err;
		amt = r.amount;
		y0 = r.year;
		m0 = r.month;
		d0 = r.day;
		y = y0;
		m = m0;
		d = d0;
		err = 1'b0;
		if (m0 < 1 || m0 > 12) begin
			err = 1'b1;
		end else begin
			case (r.op)
				cda_pkg::OP_DAYS: begin
					d = d0 + amt;
					while (d > month_length(y, m) || d <= 0) begin
						if (d > 0) begin
							d -= month_length(y, m);
							if (m == 12) begin
								m = 1;
								y++;
							end else begin
								m++;
							end
						end else begin
							if (m == 1) begin
								m = 12;
								y--;
							end else begin
								m--;
							end
							d += month_length(y, m);
						end
					end
				end
				cda_pkg::OP_MONTHS: begin
					s = m0 + amt;
					if (s > 12) begin
						y += (s - 1) / 12;
						m = (s - 1) % 12 + 1;
					end else if (s < 1) begin
						n = (12 - s) / 12;
						y -= n;
						m = s + 12 * n;
					end else begin
						m = s;
					end
					if (y >= 0 && y <= cda_pkg::YEAR_MAX) begin
						lim = month_length(y, m);
						if (d > lim) begin
							d = lim;
						end
					end
				end
				cda_pkg::OP_YEARS: begin
					y = y0 + amt;
				end
				default: begin
					err = 1'b1;
				end
			endcase
		end
		if (!err && (y < 0 || y > cda_pkg::YEAR_MAX)) begin
			err = 1'b1;
		end
		if (err) begin
			y = y0;
			m = m0;
			d = d0;
		end
		res.year = y[13:0];
		res.month = m[3:0];
		res.day = d[6:0];
		res.err = err;
		return res;
	endfunction

	// ---------------------------------------------------------------- request side

	task automatic send_request(input logic [1:0] op, input int amt, input int yr,
			input int mon, input int dy);
		date_req_t req;
		date_sum_t predicted;
		int gap;
		req.op = op;
		req.amount = amt[15:0];
		req.year = yr[13:0];
		req.month = mon[3:0];
		req.day = dy[6:0];
		gap = send_burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			request_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		request_ch.operation = req.op;
		request_ch.amount = req.amount;
		request_ch.in_year = req.year;
		request_ch.in_month = req.month;
		request_ch.in_day = req.day;
		request_ch.valid = 1'b1;
		do @(posedge clk); while (request_ch.ready !== 1'b1);
		predicted = add_to_date(req);
		pending_dates.push_back(predicted);
		case (req.op)
			cda_pkg::OP_DAYS:   sent_days++;
			cda_pkg::OP_MONTHS: sent_months++;
			cda_pkg::OP_YEARS:  sent_years++;
			default:   ;
		endcase
		if (predicted.err) begin
			sent_rejected++;
		end
		@(negedge clk);
	endtask

	function automatic int rand_year();
		case ($urandom_range(0, 5))
			0:       return $urandom_range(0, 3);
			1:       return $urandom_range(16380, 16383);
			2:       return 100 * $urandom_range(0, 163) + $urandom_range(0, 1) * 4;
			default: return $urandom_range(0, 16383);
		endcase
	endfunction

	function automatic int rand_month(input int bad_pct);
		int m;
		if ($urandom_range(1, 100) > bad_pct) begin
			return $urandom_range(1, 12);
		end
		m = $urandom_range(12, 15);
		return (m == 12) ? 0 : m;
	endfunction

	function automatic int rand_day();
		if ($urandom_range(0, 99) < 85) begin
			return $urandom_range(1, 31);
		end
		return int'($urandom_range(0, 127)) - 64;
	endfunction

	function automatic int rand_amount(input logic [1:0] op);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			return int'($urandom_range(0, 65535)) - 32768;
		end
		case (op)
			cda_pkg::OP_DAYS:   return (sel < 3) ? int'($urandom_range(0, 6000)) - 3000
				: int'($urandom_range(0, 140)) - 70;
			cda_pkg::OP_MONTHS: return int'($urandom_range(0, 80)) - 40;
			default:   return int'($urandom_range(0, 600)) - 300;
		endcase
	endfunction

	// ---------------------------------------------------------------- result side

	task automatic check_result();
		date_sum_t exp;
		results_checked++;
		if (pending_dates.size() == 0) begin
			$error("result beat with nothing expected: year %0d month %0d day %0d err %0b",
				result_ch.out_year, result_ch.out_month, result_ch.out_day,
				result_ch.range_error);
			mismatches++;
			return;
		end
		exp = pending_dates.pop_front();
		if (result_ch.out_year !== exp.year) begin
			$error("out_year: expected %0d, got %0d", exp.year, result_ch.out_year);
			mismatches++;
		end
		if (result_ch.out_month !== exp.month) begin
			$error("out_month: expected %0d, got %0d", exp.month, result_ch.out_month);
			mismatches++;
		end
		if (result_ch.out_day !== exp.day) begin
			$error("out_day: expected %0d, got %0d", exp.day, result_ch.out_day);
			mismatches++;
		end
		if (result_ch.range_error !== exp.err) begin
			$error("range_error: expected %0b, got %0b", exp.err, result_ch.range_error);
			mismatches++;
		end
	endtask

	initial begin
		int stall;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = take_burst ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				result_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready = 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
			check_result();
			@(negedge clk);
		end
	end

	// no beat on either side for too long means the block hung
	always @(posedge clk) begin
		if (!arst_n || (request_ch.valid === 1'b1 && request_ch.ready === 1'b1)
				|| (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
			$display("calendar_date_adder regression: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	task automatic test_day_edges();
		send_request(cda_pkg::OP_DAYS, 1, 2024, 2, 28);       // into a leap day
		send_request(cda_pkg::OP_DAYS, 1, 1900, 2, 28);       // century, not leap
		send_request(cda_pkg::OP_DAYS, 1, 2000, 2, 28);       // 400 rule, leap
		send_request(cda_pkg::OP_DAYS, -1, 0, 3, 1);          // year 0 is leap
		send_request(cda_pkg::OP_DAYS, 1, 16383, 12, 31);     // walks past the top year
		send_request(cda_pkg::OP_DAYS, -1, 0, 1, 1);          // walks below year 0
		send_request(cda_pkg::OP_DAYS, 32767, 2023, 12, 31);
		send_request(cda_pkg::OP_DAYS, -32768, 2023, 1, 1);
		send_request(cda_pkg::OP_DAYS, 0, 2023, 3, -64);      // day normalized backward
		send_request(cda_pkg::OP_DAYS, 0, 2023, 3, 63);       // day normalized forward
	endtask

	task automatic test_month_edges();
		send_request(cda_pkg::OP_MONTHS, 1, 2023, 1, 31);     // clamp to 28
		send_request(cda_pkg::OP_MONTHS, 1, 2024, 1, 31);     // clamp to 29
		send_request(cda_pkg::OP_MONTHS, 12, 2023, 12, 15);   // sum of 24 stays December
		send_request(cda_pkg::OP_MONTHS, -1, 2023, 1, 15);
		send_request(cda_pkg::OP_MONTHS, -13, 2023, 1, 15);
		send_request(cda_pkg::OP_MONTHS, 3, 2023, 5, -5);     // non-positive day kept
		send_request(cda_pkg::OP_MONTHS, 1, 16383, 12, 1);
		send_request(cda_pkg::OP_MONTHS, 32767, 10, 6, 30);
		send_request(cda_pkg::OP_MONTHS, -32768, 9000, 6, 30);
	endtask

	task automatic test_year_edges();
		send_request(cda_pkg::OP_YEARS, 1, 2024, 2, 29);      // no clamp on Feb 29
		send_request(cda_pkg::OP_YEARS, 16383, 0, 7, 4);
		send_request(cda_pkg::OP_YEARS, 16383, 1, 7, 4);
		send_request(cda_pkg::OP_YEARS, -32768, 100, 7, 4);
	endtask

	task automatic test_rejects();
		send_request(cda_pkg::OP_DAYS, 5, 2023, 0, 10);
		send_request(cda_pkg::OP_MONTHS, 5, 2023, 13, 10);
		send_request(cda_pkg::OP_YEARS, 5, 2023, 15, 10);
		send_request(cda_pkg::OP_NONE, 5, 2023, 6, 10);
	endtask

	task automatic test_day_walk(input int count);
		send_burst = 1'b0;
		take_burst = 1'b0;
		repeat (count) send_request(cda_pkg::OP_DAYS, rand_amount(cda_pkg::OP_DAYS),
			rand_year(), rand_month(3), rand_day());
	endtask

	task automatic test_month_carry(input int count);
		send_burst = 1'b1;
		take_burst = 1'b0;
		repeat (count) send_request(cda_pkg::OP_MONTHS, rand_amount(cda_pkg::OP_MONTHS),
			rand_year(), rand_month(3), rand_day());
	endtask

	task automatic test_year_shift(input int count);
		send_burst = 1'b0;
		take_burst = 1'b1;
		repeat (count) send_request(cda_pkg::OP_YEARS, rand_amount(cda_pkg::OP_YEARS),
			rand_year(), rand_month(3), rand_day());
	endtask

	task automatic test_mixed_traffic(input int count);
		logic [1:0] op;
		for (int i = 0; i < count; i++) begin
			if (i % 30 == 0) begin
				send_burst = $urandom_range(0, 1);
				take_burst = $urandom_range(0, 1);
			end
			op = ($urandom_range(0, 19) == 0) ? cda_pkg::OP_NONE
				: 2'($urandom_range(0, 2));
			send_request(op, rand_amount(op), rand_year(), rand_month(20), rand_day());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		request_ch.valid = 1'b0;
		request_ch.operation = cda_pkg::OP_DAYS;
		request_ch.amount = '0;
		request_ch.in_year = '0;
		request_ch.in_month = 4'd1;
		request_ch.in_day = 7'sd1;
		send_burst = 1'b0;
		take_burst = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_day_edges();
		test_month_edges();
		test_year_edges();
		test_rejects();
		test_day_walk(170);
		test_month_carry(130);
		test_year_shift(90);
		test_mixed_traffic(125);

		request_ch.valid = 1'b0;
		while (pending_dates.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("sent %0d add-days, %0d add-months, %0d add-years requests; %0d rejected",
			sent_days, sent_months, sent_years, sent_rejected);
		$display("checked %0d result beats, %0d field mismatches", results_checked,
			mismatches);
		if (mismatches == 0) begin
			$display("calendar_date_adder regression: pass");
		end else begin
			$display("calendar_date_adder regression: fail");
		end
		$finish;
	end

endmodule
